@@ src/csa_pkg.sv @@
// shared constants for the contiguous subarray search block
// no dependencies; imported by the top level and its checker
package csa_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd3;

endpackage

@@ src/contiguous_subarray_search.sv @@
// top level of the contiguous subarray search block
// holds the text and pattern memories and the search sequencer
// depends on csa_pkg
//
// usage: one request channel (in_valid_i / in_stall_o, command_i, element_value_i)
// and one result channel (out_valid_o / out_stall_i, found_o). a request is
// taken at a rising edge with valid high and stall low.
// clear and append requests give no result; the block can take the next
// request in the following cycle. an append to a full store is dropped.
// a search holds in_stall_o high while it walks both memories, one element
// compare per cycle except after a mismatch, through a single registered read
// port on each memory; a mismatch flushes the read in flight. an empty pattern,
// or one longer than the text, answers not found without walking the memories.
// the result sits in an output register; while the receiver stalls it holds,
// and a finished search waits with in_stall_o high until the slot frees.
// reset clears both lengths and the result slot; memory contents are not
// cleared and need no clearing pass since only written entries are read.
module contiguous_subarray_search
  import csa_pkg::*;
#(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [LW-1:0]     text_len_q, text_len_d;
  logic [LW-1:0]     pat_len_q, pat_len_d;
  logic [LW-1:0]     start_q, start_d;
  logic [LW-1:0]     k_q, k_d;
  logic [LW-1:0]     last_start_q, last_start_d;
  logic [LW-1:0]     pat_last_q, pat_last_d;
  logic [LW-1:0]     rd_start_q, rd_start_d;
  logic              issue_q, issue_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic              rd_final_q, rd_final_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic              pend_q, pend_d;

  logic [DATA_W-1:0] text_mem [MAX_LEN];
  logic [DATA_W-1:0] pat_mem  [MAX_LEN];
  logic [DATA_W-1:0] text_rd_q;
  logic [DATA_W-1:0] pat_rd_q;

  logic              in_acc;
  logic              out_free;
  logic              wr_text;
  logic              wr_pat;
  logic [LW-1:0]     text_idx;
  logic [AW-1:0]     text_addr;
  logic [AW-1:0]     pat_addr;
  logic              fin;
  logic              fin_val;

  assign in_acc    = in_valid_i & (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign wr_text   = in_acc & (command_i == CMD_TEXT) & (text_len_q < LEN_MAX);
  assign wr_pat    = in_acc & (command_i == CMD_PATTERN) & (pat_len_q < LEN_MAX);
  assign text_idx  = start_q + k_q;
  assign text_addr = text_idx[AW-1:0];
  assign pat_addr  = k_q[AW-1:0];

  // writes only happen in idle and reads only matter while searching
  always_ff @(posedge clk_i) begin
    if (wr_text) begin
      text_mem[text_len_q[AW-1:0]] <= element_value_i;
    end
    text_rd_q <= text_mem[text_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_pat) begin
      pat_mem[pat_len_q[AW-1:0]] <= element_value_i;
    end
    pat_rd_q <= pat_mem[pat_addr];
  end

  always_comb begin
    state_d      = state_q;
    text_len_d   = text_len_q;
    pat_len_d    = pat_len_q;
    start_d      = start_q;
    k_d          = k_q;
    last_start_d = last_start_q;
    pat_last_d   = pat_last_q;
    rd_start_d   = rd_start_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = rd_last_q;
    rd_final_d   = rd_final_q;
    out_valid_d  = out_valid_q & out_stall_i;
    found_d      = found_q;
    pend_d       = pend_q;
    fin          = 1'b0;
    fin_val      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (command_i)
            CMD_CLEAR: begin
              text_len_d = '0;
              pat_len_d  = '0;
            end
            CMD_TEXT: begin
              if (wr_text) begin
                text_len_d = text_len_q + LEN_ONE;
              end
            end
            CMD_PATTERN: begin
              if (wr_pat) begin
                pat_len_d = pat_len_q + LEN_ONE;
              end
            end
            CMD_SEARCH: begin
              if ((pat_len_q == '0) || (pat_len_q > text_len_q)) begin
                pend_d  = 1'b0;
                state_d = ST_WAIT;
              end else begin
                start_d      = '0;
                k_d          = '0;
                issue_d      = 1'b1;
                last_start_d = text_len_q - pat_len_q;
                pat_last_d   = pat_len_q - LEN_ONE;
                state_d      = ST_SEARCH;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // issue stage
        if (issue_q) begin
          rd_vld_d   = 1'b1;
          rd_last_d  = (k_q == pat_last_q);
          rd_final_d = (start_q == last_start_q);
          rd_start_d = start_q;
          if (k_q == pat_last_q) begin
            k_d = '0;
            if (start_q == last_start_q) begin
              issue_d = 1'b0;
            end else begin
              start_d = start_q + LEN_ONE;
            end
          end else begin
            k_d = k_q + LEN_ONE;
          end
        end
        // compare stage, mismatch flushes the read in flight
        if (rd_vld_q) begin
          if (text_rd_q != pat_rd_q) begin
            rd_vld_d = 1'b0;
            if (rd_final_q) begin
              fin = 1'b1;
            end else begin
              start_d = rd_start_q + LEN_ONE;
              k_d     = '0;
              issue_d = 1'b1;
            end
          end else if (rd_last_q) begin
            fin     = 1'b1;
            fin_val = 1'b1;
          end
        end
        if (fin) begin
          issue_d  = 1'b0;
          rd_vld_d = 1'b0;
          if (out_free) begin
            out_valid_d = 1'b1;
            found_d     = fin_val;
            state_d     = ST_IDLE;
          end else begin
            pend_d  = fin_val;
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = pend_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      text_len_q  <= '0;
      pat_len_q   <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      text_len_q  <= text_len_d;
      pat_len_q   <= pat_len_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    k_q          <= k_d;
    last_start_q <= last_start_d;
    pat_last_q   <= pat_last_d;
    rd_start_q   <= rd_start_d;
    rd_last_q    <= rd_last_d;
    rd_final_q   <= rd_final_d;
    found_q      <= found_d;
    pend_q       <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

endmodule

@@ src/csa_checker.sv @@
// port-level checker for the contiguous subarray search block
// bound to contiguous_subarray_search; depends on csa_pkg
module csa_checker
  import csa_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [CMD_W-1:0] command_i,
  input logic             out_valid_o,
  input logic             out_stall_i
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a search request busies the block
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i == CMD_SEARCH) |=> in_stall_o)
    else $error("search request did not busy the block");

  // clear and append requests leave the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i != CMD_SEARCH) |=> !in_stall_o)
    else $error("load request stalled the next request");

  // a result only appears at the end of a search
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a search in progress");

endmodule

bind contiguous_subarray_search csa_checker u_csa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

@@ test/contiguous_subarray_search_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for contiguous_subarray_search: a directed table, then random
// clear/append/search requests, results checked against an in-bench search predictor or pinned values
// depends on csa_pkg and the contiguous_subarray_search top level
module contiguous_subarray_search_tb;
  import csa_pkg::*;

  localparam int unsigned MAX_LEN       = 128;
  localparam int unsigned ITEM_TARGET   = 950;
  localparam int unsigned CALM_ITEMS    = 120;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_AFTER    = 12;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned NUM_DIRECTED  = 25;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    logic              pinned;
    logic              pinned_found;
  } request_row_t;

  typedef enum int {SEQ_PLAIN, SEQ_TEXT_FULL, SEQ_BOTH_FULL} shape_e;

  // pinned rows carry an expected found typed in by hand
  localparam request_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{CMD_SEARCH,  32'h0000_0000, 1'b1, 1'b0},
    '{CMD_TEXT,    32'h8000_0000, 1'b0, 1'b0},
    '{CMD_TEXT,    32'h7FFF_FFFF, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'h0000_0000, 1'b1, 1'b0},
    '{CMD_PATTERN, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'hFFFF_FFFF, 1'b1, 1'b1},
    '{CMD_PATTERN, 32'h8000_0000, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'h0000_0000, 1'b1, 1'b0},
    '{CMD_CLEAR,   32'hFFFF_FFFF, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'h0000_0000, 1'b1, 1'b0},
    '{CMD_PATTERN, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{CMD_PATTERN, 32'h0000_0000, 1'b0, 1'b0},
    '{CMD_TEXT,    32'hFFFF_FFFF, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'h0000_0000, 1'b1, 1'b0},
    '{CMD_TEXT,    32'h0000_0000, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'hAAAA_AAAA, 1'b1, 1'b1},
    '{CMD_CLEAR,   32'h0000_0000, 1'b0, 1'b0},
    '{CMD_TEXT,    32'h0000_0005, 1'b0, 1'b0},
    '{CMD_TEXT,    32'h0000_0005, 1'b0, 1'b0},
    '{CMD_TEXT,    32'h0000_0006, 1'b0, 1'b0},
    '{CMD_PATTERN, 32'h0000_0005, 1'b0, 1'b0},
    '{CMD_PATTERN, 32'h0000_0006, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'h5555_5555, 1'b0, 1'b0},
    '{CMD_PATTERN, 32'h0000_0005, 1'b0, 1'b0},
    '{CMD_SEARCH,  32'h0000_0000, 1'b0, 1'b0}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         command_i;
  logic signed [DATA_W-1:0] element_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     found_o;

  logic [DATA_W-1:0] text_words [MAX_LEN];
  logic [DATA_W-1:0] pattern_words [MAX_LEN];
  int unsigned       text_count = 0;
  int unsigned       pattern_count = 0;
  bit                found_queue [$];

  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  contiguous_subarray_search #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit pattern_occurs();
    int unsigned s;
    int unsigned k;
    bit hit;
    if (pattern_count == 0 || pattern_count > text_count) return 1'b0;
    for (s = 0; s + pattern_count <= text_count; s++) begin
      hit = 1'b1;
      for (k = 0; k < pattern_count; k++) begin
        if (text_words[s + k] != pattern_words[k]) hit = 1'b0;
      end
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic track_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                               input bit pinned, input bit pinned_found);
    case (cmd)
      CMD_CLEAR: begin
        text_count    = 0;
        pattern_count = 0;
      end
      CMD_TEXT: begin
        if (text_count < MAX_LEN) begin
          text_words[text_count] = value;
          text_count++;
        end
      end
      CMD_PATTERN: begin
        if (pattern_count < MAX_LEN) begin
          pattern_words[pattern_count] = value;
          pattern_count++;
        end
      end
      CMD_SEARCH: begin
        found_queue.push_back(pinned ? pinned_found : pattern_occurs());
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                              input bit pinned = 1'b0, input bit pinned_found = 1'b0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    element_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_request(cmd, value, pinned, pinned_found);
    sent_count++;
  endtask

  // clear, load text and pattern interleaved, then search; the pattern is
  // mostly a slice of the text, sometimes with one bit flipped; some runs append text and search again
  task automatic run_sequence(input shape_e shape);
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] text_q [$];
    logic [DATA_W-1:0] pat_q [$];
    int tlen;
    int kept;
    int plen;
    int start;
    int spot;
    int k;
    int mode;
    bit wide;
    base = $urandom;
    wide = ($urandom_range(0, 3) == 0);
    tlen = (shape == SEQ_PLAIN) ? $urandom_range(0, 20) : MAX_LEN + $urandom_range(1, 3);
    for (k = 0; k < tlen; k++) begin
      text_q.push_back(wide ? $urandom : base + $urandom_range(0, 2));
    end
    kept = (tlen > MAX_LEN) ? MAX_LEN : tlen;
    case (shape)
      SEQ_TEXT_FULL: plen = $urandom_range(1, 4);
      SEQ_BOTH_FULL: plen = MAX_LEN + 2;
      default: begin
        plen = ($urandom_range(0, 9) == 0) ? kept + $urandom_range(0, 2)
                                            : $urandom_range(1, 6);
      end
    endcase
    mode  = $urandom_range(0, 3);
    start = (plen <= kept) ? $urandom_range(0, kept - plen) : 0;
    if (shape == SEQ_TEXT_FULL) start = kept - plen;
    for (k = 0; k < plen; k++) begin
      if (start + k < kept && (shape != SEQ_PLAIN || mode < 3))
        pat_q.push_back(text_q[start + k]);
      else
        pat_q.push_back(wide ? $urandom : base + $urandom_range(0, 2));
    end
    if (mode == 2 && plen > 0) begin
      spot = $urandom_range(0, plen - 1);
      pat_q[spot] = pat_q[spot] ^ (32'h1 << $urandom_range(0, 31));
    end
    send_request(CMD_CLEAR, $urandom);
    while (text_q.size() != 0 || pat_q.size() != 0) begin
      if (text_q.size() != 0 && (pat_q.size() == 0 || $urandom_range(0, 1) == 1))
        send_request(CMD_TEXT, text_q.pop_front());
      else
        send_request(CMD_PATTERN, pat_q.pop_front());
    end
    send_request(CMD_SEARCH, $urandom);
    if (shape != SEQ_PLAIN || $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send_request(CMD_TEXT, base + $urandom_range(0, 2));
      send_request(CMD_SEARCH, $urandom);
    end
  endtask

  task automatic run_noise();
    int n;
    logic [CMD_W-1:0] cmd;
    n = $urandom_range(1, 8);
    repeat (n) begin
      cmd = CMD_W'($urandom_range(CMD_CLEAR, CMD_SEARCH));
      send_request(cmd, $urandom);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bit want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (found_queue.size() == 0) begin
        $error("found: expected none, actual %0b", found_o);
        error_count++;
      end else begin
        want = found_queue.pop_front();
        if (found_o !== want) begin
          $error("found: expected %0b, actual %0b", want, found_o);
          error_count++;
        end
      end
    end
  end

  // receiver side: short stall bursts, plus one long hold so the block backs up
  initial begin : result_pacing
    int held;
    bit hold_done;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("contiguous_subarray_search_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int row;
    int seq_idx;
    in_valid_i      <= 1'b0;
    command_i       <= CMD_CLEAR;
    element_value_i <= '0;
    rst_ni          <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (row = 0; row < NUM_DIRECTED; row++) begin
      send_request(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].value,
                   DIRECTED_ROWS[row].pinned, DIRECTED_ROWS[row].pinned_found);
    end
    seq_idx = 0;
    while (sent_count < ITEM_TARGET) begin
      calm = (sent_count + CALM_ITEMS >= ITEM_TARGET);
      if (seq_idx == 6)
        run_sequence(SEQ_TEXT_FULL);
      else if (seq_idx == 14)
        run_sequence(SEQ_BOTH_FULL);
      else if ($urandom_range(0, 4) == 0)
        run_noise();
      else
        run_sequence(SEQ_PLAIN);
      seq_idx++;
    end
    in_valid_i <= 1'b0;
    while (found_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("contiguous_subarray_search_tb OK");
    else
      $display("contiguous_subarray_search_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
src/csa_pkg.sv
src/contiguous_subarray_search.sv
src/csa_checker.sv
test/contiguous_subarray_search_tb.sv
